// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BEW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define BEW_ASSERT_NEVER(label, cond, msg) \
	`BEW_ASSERT(label, !(cond), msg)

`endif

// ----- hdl/bew_pkg.sv -----
// ----------------------------------------------------------------------------
// bew_pkg
// Widths, constants, register codes and shared types of the erosion window.
// ----------------------------------------------------------------------------
`default_nettype none

package bew_pkg;

	localparam int PIX_W        = 8;
	localparam int COORD_W      = 10;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 25;
	localparam int CFG_DIM_RAW_W = 11;
	localparam int SIZE_W       = 3;
	localparam int MASK_BITS_W  = 25;
	// clamped frame dimensions, wide enough for the largest MAX_WIDTH / MAX_HEIGHT
	localparam int DIM_W        = 13;
	// widest structuring element any build may use
	localparam int MASK_LIM     = 7;
	localparam int QUEUE_DEPTH  = 4;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MASK_MAX   = 5;

	localparam logic [PIX_W-1:0] LOW_LIMIT  = 8'd127;
	localparam logic [PIX_W-1:0] HIGH_VALUE = 8'd255;

	localparam logic [CFG_DIM_RAW_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
	localparam logic [CFG_DIM_RAW_W-1:0] RST_IMAGE_HEIGHT = 11'd480;
	localparam logic [SIZE_W-1:0]        RST_MASK_ROWS    = 3'd5;
	localparam logic [SIZE_W-1:0]        RST_MASK_COLS    = 3'd5;
	localparam logic [SIZE_W-1:0]        RST_ANCHOR_ROW   = 3'd1;
	localparam logic [SIZE_W-1:0]        RST_ANCHOR_COL   = 3'd1;
	localparam logic [MASK_BITS_W-1:0]   RST_MASK_BITS    = 25'h1FF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_MASK_ROWS    = 3'd2,
		REG_MASK_COLS    = 3'd3,
		REG_ANCHOR_ROW   = 3'd4,
		REG_ANCHOR_COL   = 3'd5,
		REG_MASK_BITS    = 3'd6
	} cfg_reg_t;

	// Clamped geometry as seen by the datapath
	typedef struct packed {
		logic [DIM_W-1:0]       width;
		logic [DIM_W-1:0]       height;
		logic [SIZE_W-1:0]      mrows;
		logic [SIZE_W-1:0]      mcols;
		logic [SIZE_W-1:0]      arow;
		logic [SIZE_W-1:0]      acol;
		logic [MASK_BITS_W-1:0] mask;
	} cfg_t;

	// Classified item handed from the front to the back
	typedef struct packed {
		logic [PIX_W-1:0]    pixel;
		logic [COORD_W-1:0]  row;
		logic [COORD_W-1:0]  col;
		logic [COORD_W-1:0]  arow;
		logic [COORD_W-1:0]  acol;
		logic                border;
		logic                complete;
		logic [MASK_LIM-1:0] newcol;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PIX_W-1:0]   value;
		logic               last;
	} res_t;

endpackage

`default_nettype wire

// ----- hdl/bew_if.sv -----
// ----------------------------------------------------------------------------
// bew_if
// Valid/ready channels of the erosion window: pixels, results, config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bew_pix_if import bew_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             frame_start;

	modport source (output valid, pixel, frame_start, input ready);
	modport sink (input valid, pixel, frame_start, output ready);
endinterface

interface bew_res_if import bew_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] out_row;
	logic [COORD_W-1:0] out_col;
	logic [PIX_W-1:0]   out_value;
	logic               last;

	modport source (output valid, out_row, out_col, out_value, last, input ready);
	modport sink (input valid, out_row, out_col, out_value, last, output ready);
endinterface

interface bew_cfg_if import bew_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/bew_ram.sv -----
// ----------------------------------------------------------------------------
// bew_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bew_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hdl/bew_queue.sv -----
// ----------------------------------------------------------------------------
// bew_queue
// Short register FIFO decoupling the classifying front from the result back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bew_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output      logic             push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output      logic             pop_valid,
	input  wire logic             pop_ready,
	output      logic [WIDTH-1:0] pop_data
);

	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNW-1:0]   count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`BEW_ASSERT(a_count_bound, count_q <= CNW'(DEPTH), "queue fill count beyond depth")
	`BEW_ASSERT(a_count_step, push && !pop |=> count_q == $past(count_q) + 1'b1, "queue fill count missed a push")

endmodule

`default_nettype wire

// ----- hdl/bew_front.sv -----
// ----------------------------------------------------------------------------
// bew_front
// Accepts pixels, tracks row and column, keeps the low-flag line store and
// classifies each pixel as border copy and/or window completion.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bew_front import bew_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MASK_MAX   = DEF_MASK_MAX
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bew_pix_if.sink    pixels,
	input  wire cfg_t  cfg,
	output      logic  push_valid,
	input  wire logic  push_ready,
	output      item_t push_item
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int S  = MASK_MAX - 1;
	localparam int SW = (S > 1) ? $clog2(S) : 1;
	localparam int IW = $clog2(2 * S) + 1;
	localparam int GW = DIM_W + 1;

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
		return (s == SW'(S - 1)) ? '0 : s + 1'b1;
	endfunction

	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [SW-1:0] slot_q;

	logic             s1_valid_q;
	logic [PIX_W-1:0] pix_s1;
	logic             low_s1;
	logic [RW-1:0]    row_s1;
	logic [CW-1:0]    col_s1;
	logic [SW-1:0]    slot_s1;

	logic          accept;
	logic          low;
	logic [GW-1:0] w_g, h_g;
	logic [GW-1:0] r0, c0, r1a, r1, c1, col_inc, row_inc;
	logic [SW-1:0] s0, s1a, cur_slot, slot_d;
	logic [RW-1:0] cur_row, row_d;
	logic [CW-1:0] cur_col, col_d;
	logic [S-1:0]  line_rd;

	assign pixels.ready = !s1_valid_q || push_ready;
	assign accept       = pixels.valid && pixels.ready;
	assign low          = (pixels.pixel < LOW_LIMIT);
	assign w_g          = GW'(cfg.width);
	assign h_g          = GW'(cfg.height);

	// Position of the arriving pixel, then the counters for the one after it
	always_comb begin
		r0  = pixels.frame_start ? '0 : GW'(row_q);
		c0  = pixels.frame_start ? '0 : GW'(col_q);
		s0  = pixels.frame_start ? '0 : slot_q;
		// column overrun after the width was lowered: wrap to the next row
		c1  = (c0 >= w_g) ? '0 : c0;
		r1a = (c0 >= w_g) ? r0 + 1'b1 : r0;
		s1a = (c0 >= w_g) ? slot_inc(s0) : s0;
		r1       = (r1a >= h_g) ? '0 : r1a;
		cur_slot = (r1a >= h_g) ? '0 : s1a;
		cur_row  = r1[RW-1:0];
		cur_col  = c1[CW-1:0];
		col_inc  = c1 + 1'b1;
		row_inc  = r1 + 1'b1;
		if (col_inc >= w_g) begin
			col_d = '0;
			if (row_inc >= h_g) begin
				row_d  = '0;
				slot_d = '0;
			end else begin
				row_d  = row_inc[RW-1:0];
				slot_d = slot_inc(cur_slot);
			end
		end else begin
			col_d  = col_inc[CW-1:0];
			row_d  = cur_row;
			slot_d = cur_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			slot_q     <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				row_q      <= row_d;
				col_q      <= col_d;
				slot_q     <= slot_d;
				s1_valid_q <= 1'b1;
			end else if (push_ready) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1  <= pixels.pixel;
			low_s1  <= low;
			row_s1  <= cur_row;
			col_s1  <= cur_col;
			slot_s1 <= cur_slot;
		end
	end

	// One single-bit line per stored row slot; read and write at the pixel's column
	for (genvar k = 0; k < S; k++) begin : g_line
		bew_ram #(
			.WIDTH (1),
			.DEPTH (MAX_WIDTH)
		) u_line (
			.clk   (clk),
			.we    (accept && (cur_slot == SW'(k))),
			.waddr (cur_col),
			.wdata (low),
			.re    (accept),
			.raddr (cur_col),
			.rdata (line_rd[k])
		);
	end

	// Stage 1: gather the column of low flags and classify the position
	logic [MASK_MAX-1:0] newcol;
	logic [GW-1:0]       rr, cc, mr_g, mc_g, ar_g, ac_g;
	logic                border, complete;
	logic [GW-1:0]       arow_g, acol_g;

	always_comb begin : col_gather
		logic [IW-1:0] idx;
		newcol    = '0;
		newcol[0] = low_s1;
		idx       = '0;
		for (int j = 1; j <= S; j++) begin
			// row j above sits in slot (slot - j) mod S
			idx = IW'(slot_s1) + IW'(S - j);
			if (idx >= IW'(S)) begin
				idx = idx - IW'(S);
			end
			newcol[j] = line_rd[idx[SW-1:0]];
		end
	end

	always_comb begin
		rr   = GW'(row_s1);
		cc   = GW'(col_s1);
		mr_g = GW'(cfg.mrows);
		mc_g = GW'(cfg.mcols);
		ar_g = GW'(cfg.arow);
		ac_g = GW'(cfg.acol);
		border = (rr < ar_g) || (rr + mr_g > h_g + ar_g)
		      || (cc < ac_g) || (cc + mc_g > w_g + ac_g);
		complete = (rr + 1'b1 >= mr_g) && (cc + 1'b1 >= mc_g);
		arow_g   = rr + 1'b1 - mr_g + ar_g;
		acol_g   = cc + 1'b1 - mc_g + ac_g;
	end

	assign push_valid         = s1_valid_q;
	assign push_item.pixel    = pix_s1;
	assign push_item.row      = COORD_W'(row_s1);
	assign push_item.col      = COORD_W'(col_s1);
	assign push_item.arow     = arow_g[COORD_W-1:0];
	assign push_item.acol     = acol_g[COORD_W-1:0];
	assign push_item.border   = border;
	assign push_item.complete = complete;
	assign push_item.newcol   = MASK_LIM'(newcol);

	`BEW_ASSERT(a_slot_range, slot_q <= SW'(S - 1), "line slot beyond stored rows")

endmodule

`default_nettype wire

// ----- hdl/bew_back.sv -----
// ----------------------------------------------------------------------------
// bew_back
// Shifts the low-flag window, evaluates the structuring element and issues
// the border copy and/or anchored result of each item through an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bew_back import bew_pkg::*; #(
	parameter int MASK_MAX = DEF_MASK_MAX
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  pop_valid,
	output      logic  pop_ready,
	input  wire item_t pop_item,
	bew_res_if.source  results
);

	localparam int WB  = MASK_MAX * MASK_MAX;
	localparam int MIW = $clog2(WB);

	logic [WB-1:0] window_q;
	logic          out_valid_q;
	res_t          out_q;
	logic          pend_valid_q;
	res_t          pend_q;

	logic [WB-1:0] mask_ext;
	logic [WB-1:0] eff_mask;
	logic [WB-1:0] window_next;
	logic          hit;
	logic          out_free;
	logic          pop;
	res_t          copy_res;
	res_t          anc_res;

	assign mask_ext = WB'(cfg.mask);

	// Map element entry (a,b) onto its window bit: column mc-1-b, row mr-1-a
	always_comb begin : mask_map
		logic [SIZE_W-1:0] ri;
		logic [SIZE_W-1:0] ci;
		eff_mask = '0;
		ri       = '0;
		ci       = '0;
		for (int p = 0; p < MASK_MAX; p++) begin
			for (int q = 0; q < MASK_MAX; q++) begin
				if ((SIZE_W'(p) < cfg.mcols) && (SIZE_W'(q) < cfg.mrows)) begin
					ri = cfg.mrows - 3'd1 - SIZE_W'(q);
					ci = cfg.mcols - 3'd1 - SIZE_W'(p);
					eff_mask[p*MASK_MAX+q] =
						mask_ext[MIW'(ri) * MIW'(MASK_MAX) + MIW'(ci)];
				end
			end
		end
	end

	assign window_next = {window_q[WB-MASK_MAX-1:0], pop_item.newcol[MASK_MAX-1:0]};
	assign hit         = |(eff_mask & window_next);

	assign copy_res = '{row: pop_item.row, col: pop_item.col,
	                    value: pop_item.pixel, last: !pop_item.complete};
	assign anc_res  = '{row: pop_item.arow, col: pop_item.acol,
	                    value: (hit ? '0 : HIGH_VALUE), last: 1'b1};

	assign out_free  = !out_valid_q || results.ready;
	// a second result must drain before the next item enters
	assign pop_ready = !pend_valid_q && out_free;
	assign pop       = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= '0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				window_q <= window_next;
			end
			if (out_free) begin
				if (pend_valid_q) begin
					out_valid_q  <= 1'b1;
					pend_valid_q <= 1'b0;
				end else if (pop) begin
					out_valid_q  <= pop_item.border || pop_item.complete;
					pend_valid_q <= pop_item.border && pop_item.complete;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (pop) begin
				out_q  <= pop_item.border ? copy_res : anc_res;
				pend_q <= anc_res;
			end
		end
	end

	assign results.valid     = out_valid_q;
	assign results.out_row   = out_q.row;
	assign results.out_col   = out_q.col;
	assign results.out_value = out_q.value;
	assign results.last      = out_q.last;

	`BEW_ASSERT(a_pend_needs_out, pend_valid_q |-> out_valid_q, "second result held without a first")
	`BEW_ASSERT(a_first_not_last, out_valid_q && pend_valid_q |-> !out_q.last, "first of two results marked last")

endmodule

`default_nettype wire

// ----- hdl/binary_erosion_window.sv -----
// ----------------------------------------------------------------------------
// binary_erosion_window
// Streaming binary erosion of a greyscale raster with a configurable element.
// ----------------------------------------------------------------------------
// Pixels enter in raster order at one per cycle while back-pressure does not
// hold them. A pixel yields its own border copy when the anchored element
// would leave the frame there, and the eroded value (0 or 255, low means below
// 127) of the anchored position when it completes a window, so one pixel gives
// zero, one or two results; the last result of a pixel carries last. A pixel
// with two results holds the output side longer than one with at most one,
// and a four-item queue between the classifying front and the result back
// absorbs the difference. An accepted pixel passes the front stage register
// and the queue before it is loaded into the output register. The line store
// is MASK_MAX-1 single-bit RAMs of MAX_WIDTH entries, all read and one written
// at the pixel's column in its accept cycle; it needs no clearing after reset.
// Configuration writes are taken at any time on the cfg channel and must only
// be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_erosion_window import bew_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MASK_MAX   = DEF_MASK_MAX
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bew_pix_if.sink   pixels,
	bew_res_if.source results,
	bew_cfg_if.sink   cfg
);

	logic [CFG_DIM_RAW_W-1:0] image_width_q;
	logic [CFG_DIM_RAW_W-1:0] image_height_q;
	logic [SIZE_W-1:0]        mask_rows_q;
	logic [SIZE_W-1:0]        mask_cols_q;
	logic [SIZE_W-1:0]        anchor_row_q;
	logic [SIZE_W-1:0]        anchor_col_q;
	logic [MASK_BITS_W-1:0]   mask_bits_q;

	cfg_t  geom;
	logic  q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
	item_t q_push_item, q_pop_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
			mask_rows_q    <= RST_MASK_ROWS;
			mask_cols_q    <= RST_MASK_COLS;
			anchor_row_q   <= RST_ANCHOR_ROW;
			anchor_col_q   <= RST_ANCHOR_COL;
			mask_bits_q    <= RST_MASK_BITS;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg.data[CFG_DIM_RAW_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg.data[CFG_DIM_RAW_W-1:0];
				REG_MASK_ROWS:    mask_rows_q    <= cfg.data[SIZE_W-1:0];
				REG_MASK_COLS:    mask_cols_q    <= cfg.data[SIZE_W-1:0];
				REG_ANCHOR_ROW:   anchor_row_q   <= cfg.data[SIZE_W-1:0];
				REG_ANCHOR_COL:   anchor_col_q   <= cfg.data[SIZE_W-1:0];
				REG_MASK_BITS:    mask_bits_q    <= cfg.data[MASK_BITS_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp sizes to their legal ranges; anchors stay inside the element
	always_comb begin
		if (image_width_q == '0) begin
			geom.width = DIM_W'(1);
		end else if (DIM_W'(image_width_q) > DIM_W'(MAX_WIDTH)) begin
			geom.width = DIM_W'(MAX_WIDTH);
		end else begin
			geom.width = DIM_W'(image_width_q);
		end
		if (image_height_q == '0) begin
			geom.height = DIM_W'(1);
		end else if (DIM_W'(image_height_q) > DIM_W'(MAX_HEIGHT)) begin
			geom.height = DIM_W'(MAX_HEIGHT);
		end else begin
			geom.height = DIM_W'(image_height_q);
		end
		if (mask_rows_q == '0) begin
			geom.mrows = SIZE_W'(1);
		end else if (mask_rows_q > SIZE_W'(MASK_MAX)) begin
			geom.mrows = SIZE_W'(MASK_MAX);
		end else begin
			geom.mrows = mask_rows_q;
		end
		if (mask_cols_q == '0) begin
			geom.mcols = SIZE_W'(1);
		end else if (mask_cols_q > SIZE_W'(MASK_MAX)) begin
			geom.mcols = SIZE_W'(MASK_MAX);
		end else begin
			geom.mcols = mask_cols_q;
		end
		geom.arow = (anchor_row_q < geom.mrows) ? anchor_row_q : geom.mrows - 3'd1;
		geom.acol = (anchor_col_q < geom.mcols) ? anchor_col_q : geom.mcols - 3'd1;
		geom.mask = mask_bits_q;
	end

	bew_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MASK_MAX   (MASK_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixels     (pixels),
		.cfg        (geom),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_item  (q_push_item)
	);

	bew_queue #(
		.WIDTH ($bits(item_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_item),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_item)
	);

	bew_back #(
		.MASK_MAX (MASK_MAX)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (geom),
		.pop_valid (q_pop_valid),
		.pop_ready (q_pop_ready),
		.pop_item  (q_pop_item),
		.results   (results)
	);

endmodule

`default_nettype wire
